@@ rtl/keystroke_line_editor_defines.svh @@
// assertion macros shared by the keystroke line editor rtl
`ifndef KEYSTROKE_LINE_EDITOR_DEFINES_SVH
`define KEYSTROKE_LINE_EDITOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define KLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define KLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define KLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/kle_pkg.sv @@
// types, codes, microprogram and key decoder of the keystroke line editor
`timescale 1ns / 1ps
`default_nettype none

package kle_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    // input operations
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [1:0] CFG_COMPLETION = 2'd1;
    localparam logic [1:0] CFG_HIGH_BYTES = 2'd2;

    // key codes
    localparam logic [7:0] KEY_CTRL_C = 8'd3;
    localparam logic [7:0] KEY_CTRL_D = 8'd4;
    localparam logic [7:0] KEY_BS     = 8'd8;
    localparam logic [7:0] KEY_TAB    = 8'd9;
    localparam logic [7:0] KEY_LF     = 8'd10;
    localparam logic [7:0] KEY_CR     = 8'd13;
    localparam logic [7:0] KEY_CTRL_T = 8'd20;
    localparam logic [7:0] KEY_CTRL_U = 8'd21;
    localparam logic [7:0] KEY_CTRL_W = 8'd23;
    localparam logic [7:0] KEY_CTRL_X = 8'd24;
    localparam logic [7:0] KEY_ESC    = 8'd27;
    localparam logic [7:0] KEY_SPACE  = 8'd32;
    localparam logic [7:0] KEY_DEL    = 8'd127;

    localparam logic [6:0] LINE_CAP = 7'd127;

    typedef enum logic [3:0] {
        ACT_APPEND   = 4'd0,
        ACT_ERASE    = 4'd1,
        ACT_SWAP     = 4'd2,
        ACT_BEEP     = 4'd3,
        ACT_DONE     = 4'd4,
        ACT_CANCEL   = 4'd5,
        ACT_COMPLETE = 4'd6,
        ACT_READ     = 4'd7,
        ACT_CLEARED  = 4'd8
    } act_t;

    // microprogram steps
    typedef enum logic [3:0] {
        U_IDLE, U_EMIT, U_APPEND, U_READ0, U_READ1,
        U_SW0, U_SW1, U_SW2, U_SW3, U_SW4,
        U_WD0, U_WD1, U_WD2, U_WD3
    } upc_t;

    // sequencing condition of a step
    typedef enum logic [2:0] {
        C_ALWAYS, C_DISPATCH, C_OUT_FREE, C_WALK_SPACE, C_WALK_WORD
    } cond_t;

    // read address source
    typedef enum logic [1:0] {RD_IDX, RD_CNT_M2, RD_CNT_M1, RD_N_M1} rd_t;

    // write port use
    typedef enum logic [1:0] {WR_NONE, WR_APPEND, WR_SWAP_LO, WR_SWAP_HI} wr_t;

    // load of read data into the char registers
    typedef enum logic [1:0] {LD_NONE, LD_C1, LD_C2, LD_READ} ld_t;

    // line count update
    typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_WALK} cnt_t;

    typedef struct packed {
        cond_t cond;
        upc_t  target;
        rd_t   rd;
        wr_t   wr;
        ld_t   ld;
        cnt_t  cnt;
    } ucw_t;

    // line count change made while dispatching
    typedef enum logic [1:0] {DC_KEEP, DC_DEC, DC_KILL, DC_ZERO} dcnt_t;

    typedef struct packed {
        upc_t  entry;
        act_t  action;
        dcnt_t mode;
    } dsp_t;

    function automatic ucw_t uw(input cond_t c, input upc_t t, input rd_t r,
                                input wr_t w, input ld_t l, input cnt_t n);
        ucw_t u;
        u.cond   = c;
        u.target = t;
        u.rd     = r;
        u.wr     = w;
        u.ld     = l;
        u.cnt    = n;
        return u;
    endfunction

    // control store
    function automatic ucw_t kle_ucode(input upc_t pc);
        ucw_t u;
        unique case (pc)
            U_IDLE:   u = uw(C_DISPATCH,   U_IDLE, RD_IDX,    WR_NONE,    LD_NONE, CNT_KEEP);
            U_EMIT:   u = uw(C_OUT_FREE,   U_IDLE, RD_IDX,    WR_NONE,    LD_NONE, CNT_KEEP);
            U_APPEND: u = uw(C_ALWAYS,     U_EMIT, RD_IDX,    WR_APPEND,  LD_NONE, CNT_INC);
            U_READ0:  u = uw(C_ALWAYS,     U_READ1, RD_IDX,   WR_NONE,    LD_NONE, CNT_KEEP);
            U_READ1:  u = uw(C_ALWAYS,     U_EMIT, RD_IDX,    WR_NONE,    LD_READ, CNT_KEEP);
            U_SW0:    u = uw(C_ALWAYS,     U_SW1,  RD_CNT_M2, WR_NONE,    LD_NONE, CNT_KEEP);
            U_SW1:    u = uw(C_ALWAYS,     U_SW2,  RD_CNT_M1, WR_NONE,    LD_C2,   CNT_KEEP);
            U_SW2:    u = uw(C_ALWAYS,     U_SW3,  RD_CNT_M1, WR_NONE,    LD_C1,   CNT_KEEP);
            U_SW3:    u = uw(C_ALWAYS,     U_SW4,  RD_CNT_M1, WR_SWAP_LO, LD_NONE, CNT_KEEP);
            U_SW4:    u = uw(C_ALWAYS,     U_EMIT, RD_CNT_M1, WR_SWAP_HI, LD_NONE, CNT_KEEP);
            U_WD0:    u = uw(C_ALWAYS,     U_WD1,  RD_N_M1,   WR_NONE,    LD_NONE, CNT_KEEP);
            U_WD1:    u = uw(C_WALK_SPACE, U_WD2,  RD_N_M1,   WR_NONE,    LD_NONE, CNT_KEEP);
            U_WD2:    u = uw(C_WALK_WORD,  U_WD3,  RD_N_M1,   WR_NONE,    LD_NONE, CNT_KEEP);
            U_WD3:    u = uw(C_ALWAYS,     U_EMIT, RD_N_M1,   WR_NONE,    LD_NONE, CNT_WALK);
            default:  u = uw(C_ALWAYS,     U_IDLE, RD_IDX,    WR_NONE,    LD_NONE, CNT_KEEP);
        endcase
        return u;
    endfunction

    // classifies an incoming word and picks the microprogram entry
    function automatic dsp_t kle_dispatch(input logic [1:0] op, input logic [7:0] key,
                                          input logic [6:0] cnt, input logic [6:0] lim,
                                          input logic comp_en, input logic high_en);
        dsp_t d;
        d.entry  = U_EMIT;
        d.action = ACT_BEEP;
        d.mode   = DC_KEEP;
        unique case (op)
            OP_KEY: begin
                if (key == KEY_CR || key == KEY_LF) begin
                    d.action = ACT_DONE;
                end else if (key == KEY_CTRL_C) begin
                    d.action = ACT_CANCEL;
                end else if (comp_en && (key == KEY_CTRL_D || key == KEY_TAB)) begin
                    d.action = ACT_COMPLETE;
                end else if (key == KEY_BS || key == KEY_DEL) begin
                    if (cnt != 7'd0) begin
                        d.action = ACT_ERASE;
                        d.mode   = DC_DEC;
                    end
                end else if (key == KEY_CTRL_U || key == KEY_CTRL_X || key == KEY_ESC) begin
                    d.action = ACT_ERASE;
                    d.mode   = DC_KILL;
                end else if (key == KEY_CTRL_T) begin
                    if (cnt >= 7'd2) begin
                        d.entry  = U_SW0;
                        d.action = ACT_SWAP;
                    end
                end else if (key == KEY_CTRL_W) begin
                    if (cnt != 7'd0) begin
                        d.entry  = U_WD0;
                        d.action = ACT_ERASE;
                    end
                end else if (key < KEY_SPACE) begin
                    d.action = ACT_BEEP;
                end else if (key[7] && !high_en) begin
                    d.action = ACT_BEEP;
                end else if (cnt < lim) begin
                    d.entry  = U_APPEND;
                    d.action = ACT_APPEND;
                end
            end
            OP_READ: begin
                d.entry  = U_READ0;
                d.action = ACT_READ;
            end
            OP_CLEAR: begin
                d.action = ACT_CLEARED;
                d.mode   = DC_ZERO;
            end
            default: begin
                // unused op: swallowed with no result
                d.entry = U_IDLE;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kle_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module kle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kle_pkg::BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/keystroke_line_editor.sv @@
// top level of the keystroke line editor: microcoded sequencer over a line store
//
//  channel  | direction | payload (low bit first)                          | words
//  s_       | in        | op[1:0] key[9:2] read_index[16:10], pad to 24    | 1 per item
//  m_       | out       | action erase_count char_first char_second        | 1 per item
//           |           | line_length, pad to 40                           |
//  cfg_     | in        | cfg_index selects register, cfg_data value       | always ready
//
// an item runs through its microprogram steps from accept to result: status keys and clear
// go straight to emit, append writes the store, read reads it and swap reads and rewrites it;
// word erase walks back a character at a time, paced by the line store's single read port.
// a new word is taken only once the previous one has been handed to the output register.
// reset is synchronous: it clears the line count, output valid and sequencer and resets the config
// registers; the store is not cleared. a stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps
`default_nettype none

module keystroke_line_editor #(
    parameter int BUFFER_DEPTH = kle_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op, key, read_index
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // action, erase_count, char_first, char_second, line_length
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

`include "keystroke_line_editor_defines.svh"

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int LIM_CAP = (BUFFER_DEPTH < 127) ? BUFFER_DEPTH : 127;

    kle_pkg::upc_t  upc_reg, upc_next;
    kle_pkg::ucw_t  ucw;
    kle_pkg::dsp_t  dsp;
    kle_pkg::act_t  act_reg, act_next;

    logic [6:0]  max_len_reg, max_len_next;
    logic        comp_reg, comp_next;
    logic        high_reg, high_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  n_reg, n_next;
    logic [7:0]  key_reg, key_next;
    logic [6:0]  idx_reg, idx_next;
    logic [6:0]  erase_reg, erase_next;
    logic [7:0]  c1_reg, c1_next;
    logic [7:0]  c2_reg, c2_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    logic [1:0]    s_op;
    logic [7:0]    s_key;
    logic [6:0]    s_idx;
    logic          accept;
    logic          out_free;
    logic          walk_hit;
    logic          idx_ok;
    logic [6:0]    lim;
    logic [6:0]    rd_pos;
    logic [6:0]    wr_pos;
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          in_walk;
    logic          emit_go;

    assign s_op  = s_tdata[1:0];
    assign s_key = s_tdata[9:2];
    assign s_idx = s_tdata[16:10];

    assign s_tready  = (upc_reg == kle_pkg::U_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign lim    = (max_len_reg > 7'(LIM_CAP)) ? 7'(LIM_CAP) : max_len_reg;
    assign idx_ok = (int'(idx_reg) < BUFFER_DEPTH);

    assign in_walk = (upc_reg == kle_pkg::U_WD1) || (upc_reg == kle_pkg::U_WD2);
    assign emit_go = (upc_reg == kle_pkg::U_EMIT) && out_free;

    assign ucw = kle_pkg::kle_ucode(upc_reg);
    assign dsp = kle_pkg::kle_dispatch(s_op, s_key, cnt_reg, lim, comp_reg, high_reg);

    always_comb begin
        case (ucw.cond)
            kle_pkg::C_WALK_SPACE: walk_hit = (n_reg != 7'd0) && (ram_rdata == kle_pkg::KEY_SPACE);
            kle_pkg::C_WALK_WORD:  walk_hit = (n_reg != 7'd0) && (ram_rdata != kle_pkg::KEY_SPACE);
            default:               walk_hit = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        upc_next = upc_reg;
        n_next   = n_reg;
        unique case (ucw.cond) inside
            kle_pkg::C_ALWAYS: begin
                upc_next = ucw.target;
            end
            kle_pkg::C_DISPATCH: begin
                if (accept) begin
                    upc_next = dsp.entry;
                    n_next   = cnt_reg;
                end
            end
            kle_pkg::C_OUT_FREE: begin
                if (out_free) begin
                    upc_next = ucw.target;
                end
            end
            kle_pkg::C_WALK_SPACE, kle_pkg::C_WALK_WORD: begin
                // read data belongs to position n-1; keep walking while it matches
                if (walk_hit) begin
                    n_next = n_reg - 7'd1;
                end else begin
                    upc_next = ucw.target;
                end
            end
            default: begin
                upc_next = kle_pkg::U_IDLE;
            end
        endcase
    end

    // store addressing
    always_comb begin
        unique case (ucw.rd)
            kle_pkg::RD_IDX:    rd_pos = idx_reg;
            kle_pkg::RD_CNT_M2: rd_pos = cnt_reg - 7'd2;
            kle_pkg::RD_CNT_M1: rd_pos = cnt_reg - 7'd1;
            kle_pkg::RD_N_M1:   rd_pos = n_next - 7'd1;
            default:            rd_pos = idx_reg;
        endcase
        ram_we    = 1'b1;
        wr_pos    = cnt_reg;
        ram_wdata = key_reg;
        unique case (ucw.wr)
            kle_pkg::WR_NONE: begin
                ram_we = 1'b0;
            end
            kle_pkg::WR_APPEND: begin
                wr_pos    = cnt_reg;
                ram_wdata = key_reg;
            end
            kle_pkg::WR_SWAP_LO: begin
                wr_pos    = cnt_reg - 7'd2;
                ram_wdata = c1_reg;
            end
            kle_pkg::WR_SWAP_HI: begin
                wr_pos    = cnt_reg - 7'd1;
                ram_wdata = c2_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    kle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(wr_pos)),
        .wr_data (ram_wdata),
        .rd_addr (AW'(rd_pos)),
        .rd_data (ram_rdata)
    );

    // datapath
    always_comb begin
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        act_next   = act_reg;
        erase_next = erase_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;

        if (ucw.cond == kle_pkg::C_DISPATCH && accept) begin
            key_next   = s_key;
            idx_next   = s_idx;
            act_next   = dsp.action;
            erase_next = 7'd0;
            c1_next    = (dsp.entry == kle_pkg::U_APPEND) ? s_key : 8'd0;
            c2_next    = 8'd0;
            unique case (dsp.mode)
                kle_pkg::DC_KEEP: ;
                kle_pkg::DC_DEC: begin
                    cnt_next   = cnt_reg - 7'd1;
                    erase_next = 7'd1;
                end
                kle_pkg::DC_KILL: begin
                    cnt_next   = 7'd0;
                    erase_next = cnt_reg;
                end
                kle_pkg::DC_ZERO: begin
                    cnt_next = 7'd0;
                end
                default: ;
            endcase
        end

        unique case (ucw.cnt)
            kle_pkg::CNT_KEEP: ;
            kle_pkg::CNT_INC: begin
                cnt_next = cnt_reg + 7'd1;
            end
            kle_pkg::CNT_WALK: begin
                cnt_next   = n_reg;
                erase_next = cnt_reg - n_reg;
            end
            default: ;
        endcase

        unique case (ucw.ld)
            kle_pkg::LD_NONE: ;
            kle_pkg::LD_C1:   c1_next = ram_rdata;
            kle_pkg::LD_C2:   c2_next = ram_rdata;
            kle_pkg::LD_READ: c1_next = idx_ok ? ram_rdata : 8'd0;
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (ucw.cond == kle_pkg::C_OUT_FREE && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, cnt_reg, c2_reg, c1_reg, erase_reg, act_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // configuration registers
    always_comb begin
        max_len_next = max_len_reg;
        comp_next    = comp_reg;
        high_next    = high_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kle_pkg::CFG_MAX_LENGTH: max_len_next = cfg_data;
                kle_pkg::CFG_COMPLETION: comp_next    = cfg_data[0];
                kle_pkg::CFG_HIGH_BYTES: high_next    = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= kle_pkg::U_IDLE;
            cnt_reg      <= 7'd0;
            max_len_reg  <= kle_pkg::LINE_CAP;
            comp_reg     <= 1'b0;
            high_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            cnt_reg      <= cnt_next;
            max_len_reg  <= max_len_next;
            comp_reg     <= comp_next;
            high_reg     <= high_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        act_reg     <= act_next;
        erase_reg   <= erase_next;
        c1_reg      <= c1_next;
        c2_reg      <= c2_next;
        m_tdata_reg <= m_tdata_next;
    end

    `KLE_ASSERT_NOW(a_cnt_cap, aclk, aresetn, 1'b1, cnt_reg <= 7'(LIM_CAP), "line count past cap")
    `KLE_ASSERT_NOW(a_walk_bound, aclk, aresetn, in_walk, n_reg <= cnt_reg, "walk past line end")
    `KLE_ASSERT_NEXT(a_emit_loads, aclk, aresetn, emit_go, m_tvalid_reg && s_tready, "emit lost")

endmodule

`default_nettype wire

@@ test/kle_echo_checker.sv @@
// checker for the keystroke line editor: predicts every echo word and compares it
`timescale 1ns / 1ps

module kle_echo_checker
    import kle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // op, key, read_index
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // action, erase_count, char_first, char_second, line_length
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          echoes_checked,
    output bit   [8:0]  actions_seen
);

    typedef struct packed {
        act_t       action;
        logic [6:0] erased;
        logic [7:0] first;
        logic [7:0] second;
        logic [6:0] length;
    } echo_t;

    // predicted editor state
    logic [7:0] line_buf [0:127];
    logic [6:0] line_len;
    logic [6:0] max_len;
    logic       comp_en;
    logic       high_en;

    echo_t  echo_q [$];
    int     err_cnt;
    int     seen_cnt;
    bit [8:0] seen_mask;

    function automatic echo_t edit_line(input logic [1:0] op, input logic [7:0] key,
                                        input logic [6:0] idx);
        echo_t      e;
        logic [6:0] n;
        logic [7:0] t;
        e = '{action: ACT_BEEP, erased: 7'd0, first: 8'd0, second: 8'd0, length: 7'd0};
        n = line_len;
        if (op == OP_READ) begin
            e.action = ACT_READ;
            e.first  = line_buf[idx];
        end else if (op == OP_CLEAR) begin
            e.action = ACT_CLEARED;
            line_len = 7'd0;
        end else if (key == KEY_CR || key == KEY_LF) begin
            e.action = ACT_DONE;
        end else if (key == KEY_CTRL_C) begin
            e.action = ACT_CANCEL;
        end else if (comp_en && (key == KEY_CTRL_D || key == KEY_TAB)) begin
            e.action = ACT_COMPLETE;
        end else if (key == KEY_BS || key == KEY_DEL) begin
            if (n != 7'd0) begin
                e.action = ACT_ERASE;
                e.erased = 7'd1;
                line_len = n - 7'd1;
            end
        end else if (key == KEY_CTRL_U || key == KEY_CTRL_X || key == KEY_ESC) begin
            e.action = ACT_ERASE;
            e.erased = n;
            line_len = 7'd0;
        end else if (key == KEY_CTRL_T) begin
            if (n >= 7'd2) begin
                t = line_buf[n - 7'd2];
                line_buf[n - 7'd2] = line_buf[n - 7'd1];
                line_buf[n - 7'd1] = t;
                e.action = ACT_SWAP;
                e.first  = line_buf[n - 7'd2];
                e.second = line_buf[n - 7'd1];
            end
        end else if (key == KEY_CTRL_W) begin
            if (n != 7'd0) begin
                // trailing blanks first, then the word before them
                while (n != 7'd0 && line_buf[n - 7'd1] == KEY_SPACE) n--;
                while (n != 7'd0 && line_buf[n - 7'd1] != KEY_SPACE) n--;
                e.action = ACT_ERASE;
                e.erased = line_len - n;
                line_len = n;
            end
        end else if (key < KEY_SPACE) begin
            e.action = ACT_BEEP;
        end else if (key[7] && !high_en) begin
            e.action = ACT_BEEP;
        end else if (n < max_len) begin
            line_buf[n] = key;
            line_len = n + 7'd1;
            e.action = ACT_APPEND;
            e.first  = key;
        end
        e.length = line_len;
        return e;
    endfunction

    task automatic compare_echo(input echo_t want, input echo_t got);
        if (got.action !== want.action) begin
            err_cnt++;
            $error("action: expected %0d, got %0d", want.action, got.action);
        end
        if (got.erased !== want.erased) begin
            err_cnt++;
            $error("erase_count: expected %0d, got %0d", want.erased, got.erased);
        end
        if (got.first !== want.first) begin
            err_cnt++;
            $error("char_first: expected %0d, got %0d", want.first, got.first);
        end
        if (got.second !== want.second) begin
            err_cnt++;
            $error("char_second: expected %0d, got %0d", want.second, got.second);
        end
        if (got.length !== want.length) begin
            err_cnt++;
            $error("line_length: expected %0d, got %0d", want.length, got.length);
        end
    endtask

    always @(posedge aclk) begin
        echo_t      want;
        echo_t      got;
        logic [1:0] op;
        if (!aresetn) begin
            line_len  = 7'd0;
            max_len   = LINE_CAP;
            comp_en   = 1'b0;
            high_en   = 1'b0;
            err_cnt   = 0;
            seen_cnt  = 0;
            seen_mask = '0;
            echo_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_LENGTH: max_len = cfg_data;
                    CFG_COMPLETION: comp_en = cfg_data[0];
                    CFG_HIGH_BYTES: high_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.action = act_t'(m_tdata[3:0]);
                got.erased = m_tdata[10:4];
                got.first  = m_tdata[18:11];
                got.second = m_tdata[26:19];
                got.length = m_tdata[33:27];
                if (echo_q.size() == 0) begin
                    err_cnt++;
                    $error("echo word %h arrived with nothing expected", m_tdata);
                end else begin
                    want = echo_q.pop_front();
                    compare_echo(want, got);
                    seen_cnt++;
                end
            end
            op = s_tdata[1:0];
            // the unused op is swallowed without an echo
            if (s_tvalid && s_tready && (op == OP_KEY || op == OP_READ || op == OP_CLEAR)) begin
                want = edit_line(op, s_tdata[9:2], s_tdata[16:10]);
                echo_q.push_back(want);
                seen_mask[want.action] = 1'b1;
            end
        end
        mismatches     <= err_cnt;
        outstanding    <= echo_q.size();
        echoes_checked <= seen_cnt;
        actions_seen   <= seen_mask;
    end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for the keystroke line editor
`timescale 1ns / 1ps

module testbench;
    import kle_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int TAIL_CYCLES  = 140;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int PHASE_WORDS  = 180;
    localparam int FILL_WORDS   = 127;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // op, key, read_index
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // action, erase_count, char_first, char_second, line_length
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data  = '0;

    int       mismatches;
    int       outstanding;
    int       echoes_checked;
    bit [8:0] actions_seen;

    int cycles     = 0;
    int words_sent = 0;
    int settings   = 0;
    int hold_req   = 0;
    int burst_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    keystroke_line_editor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kle_echo_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .echoes_checked (echoes_checked),
        .actions_seen   (actions_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] key,
                             input logic [6:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, idx, key, op};
        do @(posedge aclk); while (!s_tready);
        if (op != OP_NONE) words_sent++;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // waits for every echo, then lets an unanswered word finish
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [6:0] maxl, input logic comp, input logic high);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= maxl;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_COMPLETION;
        cfg_data  <= {6'($urandom_range(0, 63)), comp};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_HIGH_BYTES;
        cfg_data  <= {6'($urandom_range(0, 63)), high};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // typing with edits mixed in; reads stay within the filled part of the store
    task automatic random_word();
        int         r;
        logic [1:0] op;
        logic [7:0] key;
        logic [6:0] idx;
        r   = $urandom_range(0, 99);
        op  = OP_KEY;
        key = 8'($urandom_range(0, 255));
        idx = 7'($urandom_range(0, 127));
        if (r < 42) begin
            key = 8'($urandom_range(33, 126));
        end else if (r < 54) begin
            key = KEY_SPACE;
        end else if (r < 60) begin
            key = $urandom_range(0, 1) ? KEY_BS : KEY_DEL;
        end else if (r < 65) begin
            key = KEY_CTRL_W;
        end else if (r < 69) begin
            key = KEY_CTRL_T;
        end else if (r < 72) begin
            case ($urandom_range(0, 2))
                0: key = KEY_CTRL_U;
                1: key = KEY_CTRL_X;
                default: key = KEY_ESC;
            endcase
        end else if (r < 75) begin
            case ($urandom_range(0, 2))
                0: key = KEY_CR;
                1: key = KEY_LF;
                default: key = KEY_CTRL_C;
            endcase
        end else if (r < 78) begin
            key = $urandom_range(0, 1) ? KEY_TAB : KEY_CTRL_D;
        end else if (r < 83) begin
            key = 8'($urandom_range(128, 255));
        end else if (r < 89) begin
            // any byte at all
        end else if (r < 95) begin
            op  = OP_READ;
            idx = 7'($urandom_range(0, 126));
        end else if (r < 97) begin
            op = OP_CLEAR;
        end else begin
            op = OP_NONE;
        end
        send_word(op, key, idx);
    endtask

    initial begin : result_sink
        int hold_left;
        int stall_left;
        int run_left;
        int holds_served;
        hold_left    = 0;
        stall_left   = 0;
        run_left     = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else begin
                run_left   = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(10, 80);
                stall_left = pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int         p;
        int         target;
        logic [7:0] key;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edits on an empty line, then on a short typed line
        send_word(OP_KEY, KEY_BS, 7'd0);
        send_word(OP_KEY, KEY_CTRL_W, 7'd0);
        send_word(OP_KEY, KEY_CTRL_T, 7'd0);
        send_word(OP_KEY, KEY_CTRL_U, 7'd0);
        send_word(OP_KEY, 8'h00, 7'd0);
        send_word(OP_KEY, 8'hFF, 7'd0);
        send_word(OP_KEY, KEY_SPACE, 7'd0);
        send_word(OP_KEY, 8'h61, 7'd0);
        send_word(OP_KEY, KEY_CTRL_T, 7'd0);
        send_word(OP_KEY, 8'h7E, 7'd0);
        send_word(OP_KEY, KEY_CTRL_T, 7'd0);
        send_word(OP_READ, 8'h00, 7'd0);
        send_word(OP_READ, 8'h00, 7'd2);
        // completion off: tab and ctrl-d are plain control bytes
        send_word(OP_KEY, KEY_TAB, 7'd0);
        send_word(OP_KEY, KEY_CTRL_D, 7'd0);
        send_word(OP_KEY, KEY_CR, 7'd0);
        send_word(OP_KEY, KEY_LF, 7'd0);
        send_word(OP_KEY, KEY_CTRL_C, 7'd0);
        send_word(OP_KEY, KEY_CTRL_W, 7'd0);
        send_word(OP_KEY, 8'h62, 7'd0);
        send_word(OP_KEY, KEY_DEL, 7'd0);
        send_word(OP_NONE, 8'hFF, 7'h7F);
        send_word(OP_KEY, 8'h63, 7'd0);
        send_word(OP_CLEAR, 8'h00, 7'd0);
        drain();

        // one character line, completion and high bytes on
        configure(7'd1, 1'b1, 1'b1);
        send_word(OP_KEY, KEY_TAB, 7'd0);
        send_word(OP_KEY, KEY_CTRL_D, 7'd0);
        send_word(OP_KEY, 8'h80, 7'd0);
        send_word(OP_KEY, 8'hFF, 7'd0);
        send_word(OP_KEY, KEY_ESC, 7'd0);
        send_word(OP_KEY, KEY_CTRL_X, 7'd0);
        drain();

        // fill the whole line so that every entry the reads reach holds data
        configure(LINE_CAP, 1'b0, 1'b0);
        send_word(OP_CLEAR, 8'h00, 7'd0);
        for (p = 0; p < FILL_WORDS; p++) begin
            key = ($urandom_range(0, 3) == 0) ? KEY_SPACE : 8'($urandom_range(33, 126));
            send_word(OP_KEY, key, 7'd0);
        end
        send_word(OP_KEY, 8'h41, 7'd0);

        for (p = 0; p < 7; p++) begin
            drain();
            case (p)
                0: configure(LINE_CAP, 1'b1, 1'b1);
                1: configure(7'd0, 1'b0, 1'b1);
                2: configure(7'($urandom_range(2, 24)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                3: configure(7'd1, 1'b1, 1'b0);
                4: configure(7'd64, 1'b0, 1'b1);
                5: configure(7'($urandom_range(1, 127)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                default: configure(7'd12, 1'b1, 1'b1);
            endcase
            // result side blocked for a long while, input side keeps pushing
            if (p == 0 || p == 4) begin
                hold_req  <= hold_req + 1;
                burst_left = 30;
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                random_word();
                if (p == 2 && words_sent == target - PHASE_WORDS / 2) drain();
            end
        end
        drain();

        $display("%0d words sent under %0d register settings, %0d echo words checked",
                 words_sent, settings, echoes_checked);
        $display("actions seen, one bit per action code: %b", actions_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kle_pkg.sv
rtl/kle_ram.sv
rtl/keystroke_line_editor.sv
test/kle_echo_checker.sv
test/testbench.sv
